/* hdl/trw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trw_pkg
// Shared types, request codes and rule tables for the repetition watchdog.
// ----------------------------------------------------------------------------
package trw_pkg;

    // Request kinds carried in the input tuser bit.
    localparam logic REQ_OBSERVE = 1'b0;
    localparam logic REQ_CLEAR   = 1'b1;

    // Near-repeat tolerance: mismatches * NEAR_SCALE must not exceed the block length.
    localparam logic [9:0] NEAR_SCALE = 10'd10;

    // Control states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Detection rules in the order they are scanned.
    typedef enum logic [1:0] {
        RULE_RUN,
        RULE_EXACT3,
        RULE_EXACT2,
        RULE_NEAR
    } t_rule;

    // Tag that travels with one pair of memory reads.
    typedef struct packed {
        logic       valid;
        logic       near;
        logic       last_copy;
        logic       last_cand;
        logic       final_cmp;
        logic [5:0] blk;
        logic [7:0] len;
    } t_tag;

    // Status returned by the scanner to the control logic.
    typedef struct packed {
        logic done;
        logic hit;
    } t_scan_stat;

    // Number of copies that a rule compares.
    function automatic logic [3:0] rule_copies(input t_rule rule);
        case (rule)
            RULE_RUN:    rule_copies = 4'd8;
            RULE_EXACT3: rule_copies = 4'd3;
            RULE_EXACT2: rule_copies = 4'd2;
            RULE_NEAR:   rule_copies = 4'd3;
            default:     rule_copies = 4'd2;
        endcase
    endfunction

    // Smallest block length of a rule.
    function automatic logic [5:0] rule_blk_min(input t_rule rule);
        case (rule)
            RULE_RUN:    rule_blk_min = 6'd1;
            RULE_EXACT3: rule_blk_min = 6'd3;
            RULE_EXACT2: rule_blk_min = 6'd8;
            RULE_NEAR:   rule_blk_min = 6'd12;
            default:     rule_blk_min = 6'd1;
        endcase
    endfunction

    // Largest block length of a rule.
    function automatic logic [5:0] rule_blk_max(input t_rule rule);
        case (rule)
            RULE_RUN:    rule_blk_max = 6'd1;
            RULE_EXACT3: rule_blk_max = 6'd7;
            RULE_EXACT2: rule_blk_max = 6'd48;
            RULE_NEAR:   rule_blk_max = 6'd48;
            default:     rule_blk_max = 6'd1;
        endcase
    endfunction

    // Window length (block times copies) of a candidate.
    function automatic logic [7:0] rule_len(input t_rule rule, input logic [5:0] blk);
        case (rule)
            RULE_RUN:    rule_len = {blk[4:0], 3'b000};
            RULE_EXACT3: rule_len = {2'b00, blk} + {1'b0, blk, 1'b0};
            RULE_EXACT2: rule_len = {1'b0, blk, 1'b0};
            RULE_NEAR:   rule_len = {2'b00, blk} + {1'b0, blk, 1'b0};
            default:     rule_len = {2'b00, blk};
        endcase
    endfunction

endpackage
`default_nettype wire

/* hdl/trw_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trw_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module trw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

/* hdl/trw_scan.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trw_scan
// Walks every rule candidate one token pair per cycle, reads the pair from
// the history memory and accumulates mismatches into a hit decision.
// ----------------------------------------------------------------------------
module trw_scan
    import trw_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [$clog2(DEPTH)-1:0]   i_wp,
    input  wire logic [$clog2(DEPTH+1)-1:0] i_held,
    input  wire logic [31:0]                i_rdata_a,
    input  wire logic [31:0]                i_rdata_b,
    output logic      [$clog2(DEPTH)-1:0]   o_raddr_a,
    output logic      [$clog2(DEPTH)-1:0]   o_raddr_b,
    output t_scan_stat                      o_stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int HW = $clog2(DEPTH+1);

    logic       r_busy, n_busy;
    t_rule      r_rule, n_rule;
    logic [5:0] r_blk, n_blk;
    logic [2:0] r_cpy, n_cpy;
    logic [5:0] r_k, n_k;
    logic [7:0] r_len, n_len;
    t_tag       r_tag, n_tag;
    logic [5:0] r_diff, n_diff;
    logic       r_fail, n_fail;
    logic       r_hit, n_hit;

    logic [7:0] back_a, back_b;
    logic [8:0] cpy_blk;
    logic       last_k, last_c, last_b;
    logic       mism;
    logic [5:0] diff_now;
    logic       fail_now;

    // Ring index of the token 'back' places before the newest one.
    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] wp,
                                                input logic [7:0] back);
        logic [AW:0] wpx;
        logic [AW:0] offx;
        wpx  = {1'b0, wp};
        offx = (AW+1)'(back) + (AW+1)'(1);
        if (wpx >= offx) begin
            ring_addr = AW'(wpx - offx);
        end else begin
            ring_addr = AW'(wpx + (AW+1)'(DEPTH) - offx);
        end
    endfunction

    // Read addresses of the current pair: copy zero against copy r_cpy.
    always_comb begin
        cpy_blk   = 9'(r_cpy) * 9'(r_blk);
        back_a    = r_len - 8'd1 - {2'b00, r_k};
        back_b    = back_a - cpy_blk[7:0];
        o_raddr_a = ring_addr(i_wp, back_a);
        o_raddr_b = ring_addr(i_wp, back_b);
    end

    // Sequencer over rules, block lengths, copies and positions.
    always_comb begin
        last_k = (r_k == r_blk - 6'd1);
        last_c = ({1'b0, r_cpy} == rule_copies(r_rule) - 4'd1);
        last_b = (r_blk == rule_blk_max(r_rule));
        n_busy = r_busy;
        n_rule = r_rule;
        n_blk  = r_blk;
        n_cpy  = r_cpy;
        n_k    = r_k;
        n_len  = r_len;

        n_tag           = '0;
        n_tag.near      = (r_rule == RULE_NEAR);
        n_tag.last_copy = last_k;
        n_tag.last_cand = last_k && last_c;
        n_tag.final_cmp = last_k && last_c && last_b && (r_rule == RULE_NEAR);
        n_tag.blk       = r_blk;
        n_tag.len       = r_len;

        if (i_start) begin
            n_busy = 1'b1;
            n_rule = RULE_RUN;
            n_blk  = rule_blk_min(RULE_RUN);
            n_cpy  = 3'd1;
            n_k    = 6'd0;
            n_len  = rule_len(RULE_RUN, rule_blk_min(RULE_RUN));
        end else if (r_busy) begin
            n_tag.valid = 1'b1;
            if (!last_k) begin
                n_k = r_k + 6'd1;
            end else begin
                n_k = 6'd0;
                if (!last_c) begin
                    n_cpy = r_cpy + 3'd1;
                end else begin
                    n_cpy = 3'd1;
                    if (!last_b) begin
                        n_blk = r_blk + 6'd1;
                        n_len = rule_len(r_rule, r_blk + 6'd1);
                    end else begin
                        case (r_rule)
                            RULE_RUN:    n_rule = RULE_EXACT3;
                            RULE_EXACT3: n_rule = RULE_EXACT2;
                            RULE_EXACT2: n_rule = RULE_NEAR;
                            default:     n_busy = 1'b0;
                        endcase
                        n_blk = rule_blk_min(n_rule);
                        n_len = rule_len(n_rule, rule_blk_min(n_rule));
                    end
                end
            end
        end
    end

    // Checker on the registered read data of the previous cycle's pair.
    always_comb begin
        mism     = (i_rdata_a != i_rdata_b);
        diff_now = r_diff + {5'd0, mism};
        fail_now = r_fail
                 || (!r_tag.near && mism)
                 || (r_tag.near && r_tag.last_copy
                     && ((10'(diff_now) * NEAR_SCALE) > {4'd0, r_tag.blk}));
        n_diff = r_diff;
        n_fail = r_fail;
        n_hit  = r_hit;
        if (i_start) begin
            n_diff = 6'd0;
            n_fail = 1'b0;
            n_hit  = 1'b0;
        end else if (r_tag.valid) begin
            n_diff = r_tag.last_copy ? 6'd0 : diff_now;
            if (r_tag.last_cand) begin
                n_fail = 1'b0;
                if (!fail_now && (i_held >= HW'(r_tag.len))) begin
                    n_hit = 1'b1;
                end
            end else begin
                n_fail = fail_now;
            end
        end
    end

    // Sequencer and checker registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_tag  <= '0;
            r_fail <= 1'b0;
            r_diff <= 6'd0;
            r_hit  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_tag  <= n_tag;
            r_fail <= n_fail;
            r_diff <= n_diff;
            r_hit  <= n_hit;
        end
        r_rule <= n_rule;
        r_blk  <= n_blk;
        r_cpy  <= n_cpy;
        r_k    <= n_k;
        r_len  <= n_len;
    end

    // The decision is final once the last pair has been checked.
    assign o_stat.done = r_tag.valid && r_tag.final_cmp;
    assign o_stat.hit  = r_hit;

endmodule
`default_nettype wire

/* hdl/token_repetition_watchdog.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// token_repetition_watchdog
// Sticky detector of repetition collapse in a stream of generated tokens.
// ----------------------------------------------------------------------------
// Each input transaction is either a token to observe or a clear request
// (tuser bit set), and each yields one output transaction whose bit 0 is the
// sticky trip flag. An observed token is written into a history memory and
// then all rule candidates are scanned one token pair per cycle through the
// two read ports of that memory: the single-token run, blocks of 3 to 7
// repeated three times, blocks of 8 to 48 repeated twice and the near-repeat
// of 12 to 48 token blocks. An observed token passes from the scan state to
// the done state once the last pair is checked; a clear request, or a token
// that arrives after a trip, goes straight to the done state. From the done
// state the result is loaded into the output register, which waits while a
// previous result is still held there. The input is ready again in the cycle
// after the result is loaded. The history needs no clearing pass after reset:
// only entries written since the last clear are ever used.
// ----------------------------------------------------------------------------
module token_repetition_watchdog
    import trw_pkg::*;
#(
    parameter int HISTORY_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [31:0] token
    input  wire logic [0:0]  s_axis_tuser,  // [0] req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata   // [0] tripped, [7:1] zero
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int HW = $clog2(HISTORY_DEPTH+1);

    t_state        r_state, n_state;
    logic [AW-1:0] r_wp, n_wp;
    logic [HW-1:0] r_held, n_held;
    logic          r_trip, n_trip;
    logic          r_from_scan, n_from_scan;
    logic          r_out_valid, n_out_valid;
    logic          r_out_bit, n_out_bit;

    logic          accept;
    logic          push;
    logic          result;
    logic [AW-1:0] raddr_a, raddr_b;
    logic [31:0]   rdata_a, rdata_b;
    t_scan_stat    scan_stat;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign push   = accept && (s_axis_tuser[0] == REQ_OBSERVE) && !r_trip;
    assign result = r_trip || (r_from_scan && scan_stat.hit);

    // Token history.
    trw_ram #(
        .WIDTH (32),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .i_clk     (i_clk),
        .i_we      (push),
        .i_waddr   (r_wp),
        .i_wdata   (s_axis_tdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // Rule scanner.
    trw_scan #(
        .DEPTH (HISTORY_DEPTH)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (push),
        .i_wp      (r_wp),
        .i_held    (r_held),
        .i_rdata_a (rdata_a),
        .i_rdata_b (rdata_b),
        .o_raddr_a (raddr_a),
        .o_raddr_b (raddr_b),
        .o_stat    (scan_stat)
    );

    // Control: accept, wait for the scan, then hand the result to the output register.
    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_held      = r_held;
        n_trip      = r_trip;
        n_from_scan = r_from_scan;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_bit   = r_out_bit;
        s_axis_tready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_from_scan = 1'b0;
                    n_state     = ST_DONE;
                    if (s_axis_tuser[0] == REQ_CLEAR) begin
                        n_wp   = '0;
                        n_held = '0;
                        n_trip = 1'b0;
                    end else if (!r_trip) begin
                        n_wp        = (r_wp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + AW'(1);
                        n_held      = (r_held == HW'(HISTORY_DEPTH)) ? r_held
                                                                     : r_held + HW'(1);
                        n_from_scan = 1'b1;
                        n_state     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_stat.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_bit   = result;
                    n_trip      = result;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_held      <= '0;
            r_trip      <= 1'b0;
            r_from_scan <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_held      <= n_held;
            r_trip      <= n_trip;
            r_from_scan <= n_from_scan;
            r_out_valid <= n_out_valid;
        end
        r_out_bit <= n_out_bit;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_bit};

endmodule
`default_nettype wire
